>>> src/jet_lepton_overlap_cleaning_defines.svh
// Assertion macros shared by the overlap cleaning RTL.
`ifndef JET_LEPTON_OVERLAP_CLEANING_DEFINES_SVH
`define JET_LEPTON_OVERLAP_CLEANING_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JLOC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JLOC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/jloc_pkg.sv
// Shared types and constants for the overlap cleaning block.
package jloc_pkg;

    localparam int ETA_W = 13;
    localparam int PHI_W = 12;
    localparam int TAG_W = 8;
    localparam int CUT_W = 27;
    localparam int OBJ_W = ETA_W + PHI_W;

    localparam logic [CUT_W-1:0] CUT_RESET = 27'd68121;

    // Item opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_JET   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Status of the distance pipeline toward the controller
    typedef struct packed {
        logic busy;
        logic hit;
    } dist_stat_t;

endpackage

>>> src/jloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/jloc_dist.sv
// Pipelined squared angular distance and cut compare for one stored direction.
module jloc_dist (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic signed [jloc_pkg::ETA_W-1:0]    jet_eta,
    input  logic signed [jloc_pkg::PHI_W-1:0]    jet_phi,
    input  logic signed [jloc_pkg::ETA_W-1:0]    obj_eta,
    input  logic signed [jloc_pkg::PHI_W-1:0]    obj_phi,
    input  logic        [jloc_pkg::CUT_W-1:0]    cut,
    output jloc_pkg::dist_stat_t                 stat
);

    localparam int EW = jloc_pkg::ETA_W;
    localparam int PW = jloc_pkg::PHI_W;

    logic [EW:0]      deta;
    logic [PW-1:0]    dphi;
    logic [EW-1:0]    abs_eta;
    logic [PW-1:0]    abs_phi;

    logic             v1_reg;
    logic [EW-1:0]    ae1_reg;
    logic [PW-1:0]    ap1_reg;
    logic             v2_reg;
    logic [2*EW-1:0]  se2_reg;
    logic [2*PW-1:0]  sp2_reg;
    logic [jloc_pkg::CUT_W-1:0] sum;

    // Differences: eta widened by one bit, phi wraps modulo 2*pi
    always_comb begin
        deta = {jet_eta[EW-1], jet_eta} - {obj_eta[EW-1], obj_eta};
        dphi = jet_phi - obj_phi;
        abs_eta = deta[EW] ? EW'(~deta + 1'b1) : deta[EW-1:0];
        abs_phi = dphi[PW-1] ? (~dphi + 1'b1) : dphi;
    end

    // Valid bits of the two stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Stage 1 magnitudes, stage 2 squares
    always_ff @(posedge aclk) begin
        ae1_reg <= abs_eta;
        ap1_reg <= abs_phi;
        se2_reg <= ae1_reg * ae1_reg;
        sp2_reg <= ap1_reg * ap1_reg;
    end

    // Final sum and strict compare against the cut
    assign sum       = jloc_pkg::CUT_W'(se2_reg) + jloc_pkg::CUT_W'(sp2_reg);
    assign stat.hit  = v2_reg && (sum < cut);
    assign stat.busy = v1_reg || v2_reg;

endmodule

>>> src/jet_lepton_overlap_cleaning.sv
// Top level: jet/lepton overlap cleaning controller, direction store and distance unit.
// A clear, an add or an unused opcode goes from the accept to the completion state,
// which loads the result register and frees the input in the same cycle.
// A jet test scans the stored directions through the single read port of the
// direction memory, one entry per cycle, then drains the RAM read register and the
// distance pipeline, then enters the completion state. One item is in work at a time;
// the result register lets the next item be accepted while the previous result
// waits on m_ready, and a finished item waits in completion until that register
// frees. The direction store needs no clearing pass: only entries below the fill
// count are ever read.
`include "jet_lepton_overlap_cleaning_defines.svh"

module jet_lepton_overlap_cleaning #(
    parameter int MAX_OBJECTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [jloc_pkg::CUT_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic signed [jloc_pkg::ETA_W-1:0] s_eta,
    input  logic signed [jloc_pkg::PHI_W-1:0] s_phi,
    input  logic [jloc_pkg::TAG_W-1:0]        s_tag,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [jloc_pkg::TAG_W-1:0]        m_tag_out,
    output logic                              m_keep,
    output logic                              m_stored
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OBJECTS);
    localparam int EW = jloc_pkg::ETA_W;
    localparam int PW = jloc_pkg::PHI_W;

    jloc_pkg::state_t state_reg, state_next;

    logic [jloc_pkg::CUT_W-1:0] cut_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              idx_reg;
    logic [1:0]                 op_reg;
    logic signed [EW-1:0]       eta_reg;
    logic signed [PW-1:0]       phi_reg;
    logic [jloc_pkg::TAG_W-1:0] tag_reg;
    logic                       stored_reg;
    logic                       hit_reg;
    logic                       rd_valid_reg;
    logic                       m_valid_reg;
    logic [jloc_pkg::TAG_W-1:0] m_tag_reg;
    logic                       m_keep_reg;
    logic                       m_stored_reg;

    logic                       accept;
    logic                       has_room;
    logic                       ram_we;
    logic                       ram_re;
    logic                       out_load;
    logic [jloc_pkg::OBJ_W-1:0] ram_rdata;
    jloc_pkg::dist_stat_t       dstat;

    assign accept   = s_valid && s_ready;
    assign has_room = count_reg < CNT_MAX;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            jloc_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_opcode == jloc_pkg::OP_JET) ? jloc_pkg::ST_SCAN
                                                                : jloc_pkg::ST_DONE;
                end
            end
            jloc_pkg::ST_SCAN: begin
                if (idx_reg >= count_reg) begin
                    state_next = jloc_pkg::ST_DRAIN;
                end
            end
            jloc_pkg::ST_DRAIN: begin
                if (!rd_valid_reg && !dstat.busy) begin
                    state_next = jloc_pkg::ST_DONE;
                end
            end
            jloc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = jloc_pkg::ST_IDLE;
                end
            end
            default: state_next = jloc_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        s_ready  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            jloc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                ram_we  = s_valid && (s_opcode == jloc_pkg::OP_ADD) && has_room;
            end
            jloc_pkg::ST_SCAN:  ram_re   = idx_reg < count_reg;
            jloc_pkg::ST_DRAIN: ram_re   = 1'b0;
            jloc_pkg::ST_DONE:  out_load = !m_valid_reg || m_ready;
            default: s_ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= jloc_pkg::ST_IDLE;
            cut_reg      <= jloc_pkg::CUT_RESET;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= ram_re;
            if (cfg_wr_en) begin
                cut_reg <= cfg_wr_data;
            end
            if (accept) begin
                hit_reg <= 1'b0;
                case (s_opcode)
                    jloc_pkg::OP_CLEAR: count_reg <= '0;
                    jloc_pkg::OP_ADD:   if (has_room) count_reg <= count_reg + 1'b1;
                    default:            count_reg <= count_reg;
                endcase
            end else if (dstat.hit) begin
                hit_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_opcode;
            eta_reg    <= s_eta;
            phi_reg    <= s_phi;
            tag_reg    <= s_tag;
            stored_reg <= (s_opcode == jloc_pkg::OP_ADD) && has_room;
            idx_reg    <= '0;
        end else if (ram_re) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (out_load) begin
            m_tag_reg    <= tag_reg;
            m_keep_reg   <= (op_reg == jloc_pkg::OP_JET) && !hit_reg;
            m_stored_reg <= stored_reg;
        end
    end

    // Direction store: eta in the upper bits, phi in the lower
    jloc_ram #(
        .WIDTH(jloc_pkg::OBJ_W),
        .DEPTH(MAX_OBJECTS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({s_eta, s_phi}),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    jloc_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .jet_eta  (eta_reg),
        .jet_phi  (phi_reg),
        .obj_eta  (ram_rdata[jloc_pkg::OBJ_W-1:PW]),
        .obj_phi  (ram_rdata[PW-1:0]),
        .cut      (cut_reg),
        .stat     (dstat)
    );

    assign m_valid   = m_valid_reg;
    assign m_tag_out = m_tag_reg;
    assign m_keep    = m_keep_reg;
    assign m_stored  = m_stored_reg;

    // Checks
    `JLOC_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_MAX,
        "store count above capacity")
    `JLOC_ASSERT_NOW(a_idle_quiet, aclk, aresetn, s_ready, !dstat.busy && !rd_valid_reg,
        "distance pipeline active while idle")
    `JLOC_ASSERT_NEXT(a_add_grows, aclk, aresetn,
        accept && s_opcode == jloc_pkg::OP_ADD && has_room,
        count_reg == $past(count_reg) + 1'b1,
        "accepted add did not grow the store")
    `JLOC_ASSERT_NOW(a_result_from_done, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == jloc_pkg::ST_DONE,
        "result appeared outside completion state")

endmodule
